### design/whf_pkg.sv
// ---------------------------------------------------------------------------
// whf_pkg
// types, constants and the cordic angle table for the waypoint follower
// ---------------------------------------------------------------------------
package whf_pkg;

  localparam int TableDepth  = 16;
  localparam int CordicSteps = 16;
  localparam int IdxW        = 5;
  localparam int StepW       = 5;

  localparam logic signed [15:0] PiQ13    = 16'sd25736;
  localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;
  localparam logic signed [20:0] HalfPiQ16 = 21'sd102944;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_REACH   = 3'd0,
    CFG_GAIN    = 3'd1,
    CFG_MAXTURN = 3'd2,
    CFG_CRUISE  = 3'd3,
    CFG_SLOW    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] wp_x;
    logic signed [31:0] wp_y;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_theta;
  } req_item_t;

  typedef struct packed {
    logic [14:0]        speed_target;
    logic signed [15:0] turn_target;
    logic               add_accepted;
    logic               waypoint_reached;
    logic [4:0]         waypoint_count;
    logic [4:0]         active_index;
    logic               route_complete;
  } rsp_item_t;

  typedef struct packed {
    logic [23:0] reach_radius;
    logic [15:0] heading_gain;
    logic [14:0] max_turn_rate;
    logic [14:0] cruise_speed;
    logic [14:0] slowdown_angle;
  } cfg_t;

  // front-to-back queue entry: a classified job
  typedef struct packed {
    logic               steer;       // tick needs the cordic path
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [15:0] theta;
    rsp_item_t          rsp;         // bookkeeping result, speeds zero
  } job_t;

  function automatic logic signed [20:0] atan_q16(input logic [StepW-1:0] i);
    unique case (i)
      5'd0:  atan_q16 = 21'sd51472;
      5'd1:  atan_q16 = 21'sd30385;
      5'd2:  atan_q16 = 21'sd16055;
      5'd3:  atan_q16 = 21'sd8150;
      5'd4:  atan_q16 = 21'sd4091;
      5'd5:  atan_q16 = 21'sd2047;
      5'd6:  atan_q16 = 21'sd1024;
      5'd7:  atan_q16 = 21'sd512;
      5'd8:  atan_q16 = 21'sd256;
      5'd9:  atan_q16 = 21'sd128;
      5'd10: atan_q16 = 21'sd64;
      5'd11: atan_q16 = 21'sd32;
      5'd12: atan_q16 = 21'sd16;
      5'd13: atan_q16 = 21'sd8;
      5'd14: atan_q16 = 21'sd4;
      5'd15: atan_q16 = 21'sd2;
      5'd16: atan_q16 = 21'sd1;
      default: atan_q16 = 21'sd0;
    endcase
  endfunction

endpackage

### design/whf_if.sv
// ---------------------------------------------------------------------------
// whf_req_if / whf_rsp_if
// valid/ready channels for requests and results
// ---------------------------------------------------------------------------
interface whf_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] wp_x;
  logic signed [31:0] wp_y;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [15:0] pose_theta;
  modport source (output valid, req_type, wp_x, wp_y, pose_x, pose_y, pose_theta,
                  input ready);
  modport sink   (input valid, req_type, wp_x, wp_y, pose_x, pose_y, pose_theta,
                  output ready);
endinterface

interface whf_rsp_if;
  logic               valid;
  logic               ready;
  logic [14:0]        speed_target;
  logic signed [15:0] turn_target;
  logic               add_accepted;
  logic               waypoint_reached;
  logic [4:0]         waypoint_count;
  logic [4:0]         active_index;
  logic               route_complete;
  modport source (output valid, speed_target, turn_target, add_accepted,
                  waypoint_reached, waypoint_count, active_index, route_complete,
                  input ready);
  modport sink   (input valid, speed_target, turn_target, add_accepted,
                  waypoint_reached, waypoint_count, active_index, route_complete,
                  output ready);
endinterface

### design/waypoint_heading_follower.sv
// ---------------------------------------------------------------------------
// waypoint_heading_follower
// point-and-steer follower: waypoint table front end, cordic steering back end
// ---------------------------------------------------------------------------
// channel  dir  handshake    payload
// in_      in   valid/ready  req_type, wp_x/y, pose_x/y/theta
// out_     out  valid/ready  speed/turn targets, flags, count, index
// cfg_     in   we only      5 registers, index 0..4
// add, clear and reached ticks bypass the cordic; a steering tick runs
// 16 cordic steps in one shared shift-add unit, then error and multiply
// front and back overlap through a one-entry job register
// rst_n synchronous; table contents are not cleared
// ---------------------------------------------------------------------------
module waypoint_heading_follower (
  input  logic        clk,
  input  logic        rst_n,
  whf_req_if.sink     in_ch,
  whf_rsp_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import whf_pkg::*;

  cfg_t      cfg_r;
  req_item_t req;
  rsp_item_t rsp;
  job_t      job;
  logic      job_valid, job_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{reach_radius: 24'd6554, heading_gain: 16'd512,
                 max_turn_rate: 15'd8192, cruise_speed: 15'd2048,
                 slowdown_angle: 15'd4289};
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REACH:   cfg_r.reach_radius   <= cfg_data;
        CFG_GAIN:    cfg_r.heading_gain   <= cfg_data[15:0];
        CFG_MAXTURN: cfg_r.max_turn_rate  <= cfg_data[14:0];
        CFG_CRUISE:  cfg_r.cruise_speed   <= cfg_data[14:0];
        CFG_SLOW:    cfg_r.slowdown_angle <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign req = '{req_type: in_ch.req_type, wp_x: in_ch.wp_x, wp_y: in_ch.wp_y,
                 pose_x: in_ch.pose_x, pose_y: in_ch.pose_y,
                 pose_theta: in_ch.pose_theta};

  whf_front u_front (
    .clk, .rst_n,
    .req_valid (in_ch.valid), .req_ready (in_ch.ready), .req,
    .cfg (cfg_r), .job_valid, .job_ready, .job
  );

  whf_back u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job, .cfg (cfg_r),
    .rsp_valid (out_ch.valid), .rsp_ready (out_ch.ready), .rsp
  );

  assign out_ch.speed_target     = rsp.speed_target;
  assign out_ch.turn_target      = rsp.turn_target;
  assign out_ch.add_accepted     = rsp.add_accepted;
  assign out_ch.waypoint_reached = rsp.waypoint_reached;
  assign out_ch.waypoint_count   = rsp.waypoint_count;
  assign out_ch.active_index     = rsp.active_index;
  assign out_ch.route_complete   = rsp.route_complete;

endmodule

### design/whf_front.sv
// ---------------------------------------------------------------------------
// whf_front
// waypoint table, route bookkeeping and reach test; emits one job per request
// ---------------------------------------------------------------------------
module whf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  whf_pkg::req_item_t req,
  input  whf_pkg::cfg_t     cfg,
  output logic              job_valid,
  input  logic              job_ready,
  output whf_pkg::job_t     job
);
  import whf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_SQ   = 4'b0100,
    S_OUT  = 4'b1000
  } fst_t;

  fst_t        st_r, st_nxt;
  logic [63:0] tbl [TableDepth];
  logic [63:0] rd_r;
  logic [IdxW-1:0] cnt_r, idx_r;
  logic        done_r;
  req_item_t   req_r;
  logic signed [32:0] dx_r, dy_r;
  logic        far_r;
  logic [47:0] dx2_r, dy2_r, r2_r;
  job_t        job_r;
  logic        jv_r;

  logic signed [32:0] dx_c, dy_c;
  logic        live;
  logic        near;
  logic [48:0] d2;
  job_t        job_nxt;
  logic [IdxW-1:0] cnt_nxt, idx_nxt;
  logic        done_nxt;

  assign req_ready = (st_r == S_IDLE);
  assign job_valid = jv_r;
  assign job       = job_r;
  assign live      = (cnt_r != '0) && (idx_r < cnt_r) && !done_r;

  assign dx_c = $signed({rd_r[63], rd_r[63:32]}) - $signed({req_r.pose_x[31], req_r.pose_x});
  assign dy_c = $signed({rd_r[31], rd_r[31:0]}) - $signed({req_r.pose_y[31], req_r.pose_y});
  assign d2   = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign near = !far_r && (d2 < {1'b0, r2_r});

  always_ff @(posedge clk) begin
    if (req_valid && req_ready && req.req_type == REQ_ADD && cnt_r < IdxW'(TableDepth))
      tbl[cnt_r[3:0]] <= {req.wp_x, req.wp_y};
    rd_r <= tbl[idx_r[3:0]];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (req_valid) st_nxt = S_RD;
      S_RD:   st_nxt = S_SQ;
      S_SQ:   st_nxt = S_OUT;
      S_OUT:  if (!jv_r || job_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    job_nxt       = '0;
    job_nxt.dx    = dx_r;
    job_nxt.dy    = dy_r;
    job_nxt.theta = req_r.pose_theta;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    done_nxt = done_r;
    priority case (req_r.req_type)
      REQ_TICK: begin
        if (live && near) begin
          job_nxt.rsp.waypoint_reached = 1'b1;
          idx_nxt = idx_r + 1'b1;
          if (idx_r + 1'b1 >= cnt_r) done_nxt = 1'b1;
        end else begin
          job_nxt.steer = live;
        end
      end
      REQ_ADD: begin
        if (cnt_r < IdxW'(TableDepth)) begin
          cnt_nxt = cnt_r + 1'b1;
          job_nxt.rsp.add_accepted = 1'b1;
          if (done_r) begin
            idx_nxt = cnt_r; done_nxt = 1'b0;
          end
        end
      end
      REQ_CLEAR: begin
        cnt_nxt = '0; idx_nxt = '0; done_nxt = 1'b0;
      end
      default: ;
    endcase
    job_nxt.rsp.waypoint_count = cnt_nxt;
    job_nxt.rsp.active_index   = idx_nxt;
    job_nxt.rsp.route_complete = done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; idx_r <= '0; done_r <= 1'b0; jv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_IDLE && req_valid) req_r <= req;
      if (st_r == S_RD) begin
        dx_r  <= dx_c;
        dy_r  <= dy_c;
        far_r <= (dx_c <= -33'sd16777216) || (dx_c >= 33'sd16777216) ||
                 (dy_c <= -33'sd16777216) || (dy_c >= 33'sd16777216);
        // 25x25 signed squares; only meaningful when near range
        dx2_r <= 48'($signed(dx_c[24:0]) * $signed(dx_c[24:0]));
        dy2_r <= 48'($signed(dy_c[24:0]) * $signed(dy_c[24:0]));
        r2_r  <= cfg.reach_radius * cfg.reach_radius;
      end
      if (st_r == S_OUT && (!jv_r || job_ready)) begin
        jv_r   <= 1'b1;
        job_r  <= job_nxt;
        cnt_r  <= cnt_nxt;
        idx_r  <= idx_nxt;
        done_r <= done_nxt;
      end else if (jv_r && job_ready) begin
        jv_r <= 1'b0;
      end
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= IdxW'(TableDepth)) else $error("count beyond depth");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= cnt_r) else $error("index beyond count");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    jv_r && !job_ready |=> jv_r && $stable(job_r)) else $error("job dropped");

endmodule

### design/whf_back.sv
// ---------------------------------------------------------------------------
// whf_back
// cordic atan2, heading error, turn and speed targets; result register
// ---------------------------------------------------------------------------
module whf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  whf_pkg::job_t     job,
  input  whf_pkg::cfg_t     cfg,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output whf_pkg::rsp_item_t rsp
);
  import whf_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_ROT  = 5'b00010,
    B_ERR  = 5'b00100,
    B_MUL  = 5'b01000,
    B_OUT  = 5'b10000
  } bst_t;

  bst_t st_r;
  job_t j_r;
  logic signed [52:0] x_r, y_r;
  logic signed [21:0] z_r;
  logic [StepW-1:0]   i_r;
  logic signed [17:0] err_r;
  logic signed [34:0] prod_r;
  logic [14:0]        spd_r;
  logic               ov_r;
  rsp_item_t          o_r;
  logic               ov_nxt;

  logic signed [52:0] xs, ys;
  logic signed [17:0] ang, e0;
  logic signed [34:0] om;
  logic signed [16:0] lim;
  logic               zero_vec;
  logic               fire;
  logic signed [15:0] turn_c;
  rsp_item_t          rsp_c;

  assign job_ready = (st_r == B_IDLE);
  assign rsp_valid = ov_r;
  assign rsp       = o_r;
  assign xs  = x_r >>> i_r;
  assign ys  = y_r >>> i_r;
  // zero vector gives zero angle
  assign zero_vec = (j_r.dx == 0) && (j_r.dy == 0);
  assign ang = zero_vec ? 18'sd0 : 18'(($signed({z_r[21], z_r}) + 23'sd4) >>> 3);
  assign e0  = ang - 18'(j_r.theta);
  assign om  = (prod_r + 35'sd256) >>> 9;
  assign lim = $signed({2'b0, cfg.max_turn_rate});
  assign ov_nxt = ov_r && !rsp_ready;
  assign fire   = (st_r == B_OUT) && !ov_nxt;

  always_comb begin
    if (om > 35'(lim)) turn_c = 16'(lim);
    else if (om < -35'(lim)) turn_c = 16'(-lim);
    else turn_c = om[15:0];
    rsp_c = j_r.rsp;
    if (j_r.steer) begin
      rsp_c.speed_target = spd_r;
      rsp_c.turn_target  = turn_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE; ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt || fire;
      unique case (st_r)
        B_IDLE: if (job_valid) begin
          j_r <= job;
          i_r <= '0;
          if (!job.steer) begin
            st_r <= B_OUT;
          end else begin
            st_r <= B_ROT;
            if (job.dx < 0) begin
              if (job.dy >= 0) begin
                x_r <= 53'(job.dy); y_r <= -53'(job.dx); z_r <= 22'(HalfPiQ16);
              end else begin
                x_r <= -53'(job.dy); y_r <= 53'(job.dx); z_r <= -22'(HalfPiQ16);
              end
            end else begin
              x_r <= 53'(job.dx); y_r <= 53'(job.dy); z_r <= '0;
            end
          end
        end
        B_ROT: begin
          if (y_r >= 0) begin
            x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + 22'(atan_q16(i_r));
          end else begin
            x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - 22'(atan_q16(i_r));
          end
          i_r <= i_r + 1'b1;
          if (i_r == StepW'(CordicSteps - 1)) st_r <= B_ERR;
        end
        B_ERR: begin
          if (e0 > 18'(PiQ13)) err_r <= e0 - TwoPiQ13;
          else if (e0 < -18'(PiQ13)) err_r <= e0 + TwoPiQ13;
          else err_r <= e0;
          st_r <= B_MUL;
        end
        B_MUL: begin
          prod_r <= $signed({1'b0, cfg.heading_gain}) * err_r;
          st_r <= B_OUT;
          spd_r <= (err_r > $signed({3'b0, cfg.slowdown_angle}) ||
                    err_r < -$signed({3'b0, cfg.slowdown_angle}))
                   ? (cfg.cruise_speed >> 1) : cfg.cruise_speed;
        end
        B_OUT: if (fire) begin
          o_r  <= rsp_c;
          st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  a_turn: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !o_r.waypoint_reached && o_r.add_accepted |-> o_r.turn_target == 0)
    else $error("add carries turn");
  a_iter: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_ROT |-> i_r < StepW'(CordicSteps)) else $error("step overrun");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !rsp_ready |=> ov_r && $stable(o_r)) else $error("result lost");

endmodule

### bench/waypoint_heading_follower_tb.sv
// ---------------------------------------------------------------------------
// waypoint_heading_follower_tb
// drives add, clear, tick and none requests through the request channel and
// expects a typed literal or a prediction from a local model of the waypoint table
// and the cordic steering law; checks every result transfer field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module waypoint_heading_follower_tb;
  import whf_pkg::*;

  localparam int  NumPhases   = 8;
  localparam int  PhaseItems  = 225;
  localparam int  QuietCycles = 60;
  localparam longint CycleLimit = 1000000;

  typedef struct {
    req_item_t req;
    bit        typed;
    rsp_item_t rsp;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  logic [23:0] cfg_data;

  whf_req_if req_ch ();
  whf_rsp_if rsp_ch ();

  waypoint_heading_follower dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (req_ch),
    .out_ch   (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // local copy of the block state and registers
  logic signed [31:0] wp_tab_x [TableDepth];
  logic signed [31:0] wp_tab_y [TableDepth];
  int unsigned        wp_count;
  int unsigned        wp_active;
  bit                 route_done;
  logic [23:0]        radius_reg;
  logic [15:0]        gain_reg;
  logic [14:0]        turn_lim_reg;
  logic [14:0]        cruise_reg;
  logic [14:0]        slow_reg;

  rsp_item_t pending_rsp [$];
  bit        failed;
  bit        no_idle;
  longint    cycle_count;
  int        ready_stall;

  const longint atan_step_q16 [CordicSteps] = '{51472, 30385, 16055, 8150, 4091, 2047,
                                                1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bearing to the waypoint in q3.13 via shift-add rotation
  function automatic longint bearing_q13(longint y, longint x);
    longint z = 0;
    longint t, xs, ys;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 102944;
      end else begin
        x = -y; y = t; z = -102944;
      end
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atan_step_q16[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_step_q16[i];
      end
    end
    return (z + 4) >>> 3;
  endfunction

  function automatic rsp_item_t steer_and_book(req_item_t r);
    rsp_item_t o;
    longint dx, dy, err, omega, lim;
    bit near;
    o = '0;
    near = 1'b0;
    case (req_t'(r.req_type))
      REQ_TICK: begin
        if (wp_count != 0 && wp_active < wp_count && !route_done) begin
          dx = longint'(wp_tab_x[wp_active]) - longint'(r.pose_x);
          dy = longint'(wp_tab_y[wp_active]) - longint'(r.pose_y);
          // far points skip the distance compare
          if (dx > -16777216 && dx < 16777216 && dy > -16777216 && dy < 16777216)
            near = (dx * dx + dy * dy) < (longint'(radius_reg) * longint'(radius_reg));
          if (near) begin
            o.waypoint_reached = 1'b1;
            wp_active++;
            if (wp_active >= wp_count) route_done = 1'b1;
          end else begin
            err = bearing_q13(dy, dx) - longint'(r.pose_theta);
            if (err > 25736) err -= 51472;
            else if (err < -25736) err += 51472;
            omega = (longint'(gain_reg) * err + 256) >>> 9;
            lim = longint'(turn_lim_reg);
            if (omega > lim) omega = lim;
            if (omega < -lim) omega = -lim;
            o.turn_target = omega[15:0];
            o.speed_target = (err > longint'(slow_reg) || err < -longint'(slow_reg)) ?
                             (cruise_reg >> 1) : cruise_reg;
          end
        end
      end
      REQ_ADD: begin
        if (wp_count < TableDepth) begin
          wp_tab_x[wp_count] = r.wp_x;
          wp_tab_y[wp_count] = r.wp_y;
          wp_count++;
          o.add_accepted = 1'b1;
          if (route_done) begin
            wp_active = wp_count - 1;
            route_done = 1'b0;
          end
        end
      end
      REQ_CLEAR: begin
        wp_count = 0;
        wp_active = 0;
        route_done = 1'b0;
      end
      default: ;
    endcase
    o.waypoint_count = wp_count[4:0];
    o.active_index = wp_active[4:0];
    o.route_complete = route_done;
    return o;
  endfunction

  function automatic rsp_item_t book(bit acc, bit reached, int cnt, int idx, bit done);
    rsp_item_t o;
    o = '0;
    o.add_accepted = acc;
    o.waypoint_reached = reached;
    o.waypoint_count = cnt[4:0];
    o.active_index = idx[4:0];
    o.route_complete = done;
    return o;
  endfunction

  function automatic req_item_t mk_req(req_t kind, logic [31:0] wx, logic [31:0] wy,
                                       logic [31:0] px, logic [31:0] py, logic [15:0] th);
    req_item_t r;
    r.req_type = kind;
    r.wp_x = wx;
    r.wp_y = wy;
    r.pose_x = px;
    r.pose_y = py;
    r.pose_theta = th;
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one request transfer; the expectation is queued at acceptance
  task automatic send_req(req_item_t r, bit typed, rsp_item_t lit);
    rsp_item_t pred;
    int g;
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r.req_type;
    req_ch.wp_x <= r.wp_x;
    req_ch.wp_y <= r.wp_y;
    req_ch.pose_x <= r.pose_x;
    req_ch.pose_y <= r.pose_y;
    req_ch.pose_theta <= r.pose_theta;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pred = steer_and_book(r);
    pending_rsp.push_back(typed ? lit : pred);
    g = gap_len();
    if (g > 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_REACH:   radius_reg = val;
      CFG_GAIN:    gain_reg = val[15:0];
      CFG_MAXTURN: turn_lim_reg = val[14:0];
      CFG_CRUISE:  cruise_reg = val[14:0];
      CFG_SLOW:    slow_reg = val[14:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] near_to(logic [31:0] base);
    return base + ($urandom >>> $urandom_range(0, 31)) * (($urandom_range(0, 1) == 0) ? 1 : -1);
  endfunction

  function automatic req_item_t random_req(ref logic [31:0] last_x, ref logic [31:0] last_y);
    req_item_t r;
    int p;
    logic [31:0] bx, by;
    p = $urandom_range(0, 99);
    r = mk_req(REQ_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (p < 4) r.req_type = REQ_NONE;
    else if (p < 9) r.req_type = REQ_CLEAR;
    else if (p < 35) begin
      r.req_type = REQ_ADD;
      if ($urandom_range(0, 7) != 0) begin
        r.wp_x = near_to(last_x);
        r.wp_y = near_to(last_y);
      end
    end else begin
      if (wp_active < wp_count && $urandom_range(0, 9) != 0) begin
        bx = wp_tab_x[wp_active];
        by = wp_tab_y[wp_active];
      end else begin
        bx = last_x;
        by = last_y;
      end
      if ($urandom_range(0, 9) != 0) begin
        r.pose_x = near_to(bx);
        r.pose_y = near_to(by);
      end
      if ($urandom_range(0, 9) != 0)
        r.pose_theta = $urandom_range(0, 51472) - 25736;
      last_x = r.pose_x;
      last_y = r.pose_y;
    end
    return r;
  endfunction

  // result sink with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      ready_stall <= 0;
    end else if (ready_stall > 0) begin
      rsp_ch.ready <= 1'b0;
      ready_stall <= ready_stall - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 4) == 0)
        ready_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    rsp_item_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result transfer with nothing expected");
        failed = 1'b1;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.speed_target !== want.speed_target) begin
          $error("speed_target: expected %0d, got %0d", want.speed_target, rsp_ch.speed_target);
          failed = 1'b1;
        end
        if (rsp_ch.turn_target !== want.turn_target) begin
          $error("turn_target: expected %0d, got %0d", want.turn_target, rsp_ch.turn_target);
          failed = 1'b1;
        end
        if (rsp_ch.add_accepted !== want.add_accepted) begin
          $error("add_accepted: expected %0d, got %0d", want.add_accepted, rsp_ch.add_accepted);
          failed = 1'b1;
        end
        if (rsp_ch.waypoint_reached !== want.waypoint_reached) begin
          $error("waypoint_reached: expected %0d, got %0d",
                 want.waypoint_reached, rsp_ch.waypoint_reached);
          failed = 1'b1;
        end
        if (rsp_ch.waypoint_count !== want.waypoint_count) begin
          $error("waypoint_count: expected %0d, got %0d",
                 want.waypoint_count, rsp_ch.waypoint_count);
          failed = 1'b1;
        end
        if (rsp_ch.active_index !== want.active_index) begin
          $error("active_index: expected %0d, got %0d", want.active_index, rsp_ch.active_index);
          failed = 1'b1;
        end
        if (rsp_ch.route_complete !== want.route_complete) begin
          $error("route_complete: expected %0d, got %0d",
                 want.route_complete, rsp_ch.route_complete);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t rows [$];
    logic [31:0] last_x, last_y;
    rsp_item_t none;
    cycle_count = 0;
    failed = 1'b0;
    no_idle = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_REACH;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_NONE;
    req_ch.wp_x <= '0;
    req_ch.wp_y <= '0;
    req_ch.pose_x <= '0;
    req_ch.pose_y <= '0;
    req_ch.pose_theta <= '0;
    wp_count = 0;
    wp_active = 0;
    route_done = 1'b0;
    radius_reg = 24'd6554;
    gain_reg = 16'd512;
    turn_lim_reg = 15'd8192;
    cruise_reg = 15'd2048;
    slow_reg = 15'd4289;
    none = '0;
    last_x = '0;
    last_y = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: typed result where obvious, model otherwise
    rows.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0), 1, book(0, 0, 0, 0, 0)});
    rows.push_back('{mk_req(REQ_NONE, '1, '1, '1, '1, '1), 1, book(0, 0, 0, 0, 0)});
    rows.push_back('{mk_req(REQ_ADD, 32'h7fffffff, 32'h80000000, 0, 0, 0), 1,
                     book(1, 0, 1, 0, 0)});
    rows.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk_req(REQ_TICK, 0, 0, 32'h80000000, 32'h7fffffff, 16'sd25736), 0, none});
    rows.push_back('{mk_req(REQ_TICK, 0, 0, 32'h7fffffff, 32'h80000000, 0), 1,
                     book(0, 1, 1, 1, 1)});
    rows.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0), 1, book(0, 0, 1, 1, 1)});
    rows.push_back('{mk_req(REQ_ADD, 32'hfff60000, 32'h00050000, 0, 0, 0), 1,
                     book(1, 0, 2, 1, 0)});
    rows.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, -16'sd25736), 0, none});
    rows.push_back('{mk_req(REQ_TICK, 0, 0, 0, 32'h000a0000, 16'h7fff), 0, none});
    rows.push_back('{mk_req(REQ_TICK, 0, 0, 0, 32'h00050000, 16'h8000), 0, none});
    rows.push_back('{mk_req(REQ_TICK, 0, 0, 32'hfff60000, 32'h00050064, 0), 1,
                     book(0, 1, 2, 2, 1)});
    rows.push_back('{mk_req(REQ_CLEAR, 0, 0, 0, 0, 0), 1, book(0, 0, 0, 0, 0)});
    rows.push_back('{mk_req(REQ_ADD, 32'h00010000, 0, 0, 0, 0), 1, book(1, 0, 1, 0, 0)});
    rows.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk_req(REQ_TICK, 0, 0, 0, 32'h00020000, 16'sd25736), 0, none});
    rows.push_back('{mk_req(REQ_TICK, 0, 0, 0, 32'hfffe0000, -16'sd25736), 0, none});
    rows.push_back('{mk_req(REQ_CLEAR, 0, 0, 0, 0, 0), 1, book(0, 0, 0, 0, 0)});
    foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].rsp);

    // fill the table, the last add is rejected
    for (int i = 0; i <= TableDepth; i++)
      send_req(mk_req(REQ_ADD, near_to(0), near_to(0), 0, 0, 0), 0, none);

    for (int ph = 0; ph < NumPhases; ph++) begin
      // hold off until the block is idle before touching registers
      drain();
      no_idle = (ph == 3);
      case (ph)
        0: ;
        1: begin
          write_reg(CFG_REACH, 0);
          write_reg(CFG_GAIN, 0);
          write_reg(CFG_MAXTURN, 0);
          write_reg(CFG_CRUISE, 0);
          write_reg(CFG_SLOW, 0);
        end
        2: begin
          write_reg(CFG_REACH, 24'hffffff);
          write_reg(CFG_GAIN, 16'hffff);
          write_reg(CFG_MAXTURN, 15'h7fff);
          write_reg(CFG_CRUISE, 15'h7fff);
          write_reg(CFG_SLOW, 15'd25736);
        end
        default: begin
          write_reg(CFG_REACH, $urandom >> $urandom_range(8, 31));
          write_reg(CFG_GAIN, $urandom_range(0, 16'hffff));
          write_reg(CFG_MAXTURN, $urandom_range(0, 15'h7fff));
          write_reg(CFG_CRUISE, $urandom_range(0, 15'h7fff));
          write_reg(CFG_SLOW, $urandom_range(0, 25736));
        end
      endcase
      for (int n = 0; n < PhaseItems; n++)
        send_req(random_req(last_x, last_y), 0, none);
    end

    drain();
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
